/* rtl/bip_pkg.sv */
// Shared types and constants for the byte ISA processor core.
package bip_pkg;

	localparam int ADDR_BITS_DEF = 16;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_EXEC  = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [1:0] ST_RUN     = 2'd0;
	localparam logic [1:0] ST_HALT    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	localparam logic [7:0] OP_SET    = 8'h00;
	localparam logic [7:0] OP_LOAD   = 8'h01;
	localparam logic [7:0] OP_ADD    = 8'h02;
	localparam logic [7:0] OP_SAVE   = 8'h03;
	localparam logic [7:0] OP_CMP    = 8'h04;
	localparam logic [7:0] OP_JLT    = 8'h05;
	localparam logic [7:0] OP_JMP    = 8'h06;
	localparam logic [7:0] OP_STB    = 8'h07;
	localparam logic [7:0] OP_SET2   = 8'h08;
	localparam logic [7:0] OP_LOAD2  = 8'h09;
	localparam logic [7:0] OP_ADD2   = 8'h0A;
	localparam logic [7:0] OP_SAVE2  = 8'h0B;
	localparam logic [7:0] OP_SUB2   = 8'h0C;
	localparam logic [7:0] OP_LDB    = 8'h0D;
	localparam logic [7:0] OP_LDW    = 8'h0E;
	localparam logic [7:0] OP_STW    = 8'h0F;
	localparam logic [7:0] OP_JR     = 8'h10;
	localparam logic [7:0] OP_HALT   = 8'hFF;

	typedef enum logic [3:0] {
		S_IDLE, S_MREAD, S_F0, S_F1, S_F2, S_F3, S_F4,
		S_EXEC, S_D0, S_D1, S_D2, S_WB, S_DONE
	} state_t;

	// Memory address source select.
	typedef enum logic [1:0] {
		AS_HOST, AS_PC, AS_DATA
	} asel_t;

	typedef struct packed {
		logic       load_item;
		logic       mem_rd;
		logic       mem_wr_host;
		logic       mem_wr_data;
		asel_t      asel;
		logic [1:0] offs;
		logic [2:0] fetch_slot;
		logic       capture_data;
		logic [1:0] data_slot;
		logic       decode;
		logic       writeback;
		logic       done;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] func;
		logic       stopped;
		logic [2:0] ilen;
		logic [1:0] dacc;
		logic       dwrite;
	} stat_t;

	function automatic logic [2:0] reg_idx(input logic [7:0] code);
		reg_idx = (code[3:0] == 4'd0 && code[7:4] < 4'd6) ? code[6:4] : 3'd7;
	endfunction

endpackage

/* rtl/bip_ctrl.sv */
// Sequencer for host items and instruction fetch, access and write back.
module bip_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bip_pkg::stat_t    st,
	output bip_pkg::ctrl_t    ctl,
	output logic              busy
);
	bip_pkg::state_t state_q, state_n;
	logic [1:0] cnt_q, cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bip_pkg::S_IDLE;
			cnt_q <= 2'd0;
		end else begin
			state_q <= state_n;
			cnt_q <= cnt_n;
		end
	end

	always_comb begin
		state_n = state_q;
		cnt_n = cnt_q;
		unique case (state_q)
			bip_pkg::S_IDLE: begin
				if (start) state_n = bip_pkg::S_MREAD;
			end
			bip_pkg::S_MREAD: begin
				if (st.func == bip_pkg::FUNC_EXEC && !st.stopped) begin
					state_n = bip_pkg::S_F0;
					cnt_n = 2'd0;
				end else begin
					state_n = bip_pkg::S_DONE;
				end
			end
			// issue reads pc..pc+3, capture each byte in the next state
			bip_pkg::S_F0: state_n = bip_pkg::S_F1;
			bip_pkg::S_F1: state_n = bip_pkg::S_F2;
			bip_pkg::S_F2: state_n = bip_pkg::S_F3;
			bip_pkg::S_F3: state_n = bip_pkg::S_F4;
			bip_pkg::S_F4: state_n = bip_pkg::S_EXEC;
			// decoded access count is valid only once decode has been registered
			bip_pkg::S_EXEC: begin
				state_n = bip_pkg::S_D0;
				cnt_n = 2'd0;
			end
			bip_pkg::S_D0: begin
				if (st.dacc == 2'd0) begin
					state_n = bip_pkg::S_WB;
				end else begin
					if (cnt_q + 2'd1 == st.dacc) begin
						state_n = st.dwrite ? bip_pkg::S_WB : bip_pkg::S_D1;
					end
					cnt_n = cnt_q + 2'd1;
				end
			end
			bip_pkg::S_D1: state_n = (st.dacc == 2'd2) ? bip_pkg::S_D2 : bip_pkg::S_WB;
			bip_pkg::S_D2: state_n = bip_pkg::S_WB;
			bip_pkg::S_WB: state_n = bip_pkg::S_DONE;
			bip_pkg::S_DONE: state_n = bip_pkg::S_IDLE;
			default: state_n = bip_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.asel = bip_pkg::AS_HOST;
		busy = (state_q != bip_pkg::S_IDLE);
		unique case (state_q)
			bip_pkg::S_IDLE: begin
				ctl.load_item = start;
				ctl.mem_rd = 1'b0;
			end
			bip_pkg::S_MREAD: begin
				ctl.mem_rd = (st.func == bip_pkg::FUNC_READ);
				ctl.mem_wr_host = (st.func == bip_pkg::FUNC_WRITE);
			end
			bip_pkg::S_F0, bip_pkg::S_F1, bip_pkg::S_F2, bip_pkg::S_F3: begin
				ctl.asel = bip_pkg::AS_PC;
				ctl.mem_rd = 1'b1;
				ctl.offs = 2'(state_q - bip_pkg::S_F0);
				if (state_q != bip_pkg::S_F0) begin
					ctl.fetch_slot = 3'(state_q - bip_pkg::S_F1) + 3'd1;
				end
			end
			bip_pkg::S_F4: ctl.fetch_slot = 3'd4;
			bip_pkg::S_EXEC: ctl.decode = 1'b1;
			bip_pkg::S_D0: begin
				if (st.dacc != 2'd0) begin
					ctl.asel = bip_pkg::AS_DATA;
					ctl.offs = cnt_q;
					ctl.mem_rd = !st.dwrite;
					ctl.mem_wr_data = st.dwrite;
					// capture the byte read on the previous cycle
					ctl.data_slot = cnt_q - 2'd1;
					if (!st.dwrite && cnt_q != 2'd0) ctl.capture_data = 1'b1;
				end
			end
			bip_pkg::S_D1: begin
				ctl.capture_data = 1'b1;
				ctl.data_slot = st.dacc - 2'd1;
			end
			bip_pkg::S_D2: begin
				ctl.capture_data = 1'b1;
				ctl.data_slot = 2'd1;
			end
			bip_pkg::S_WB: ctl.writeback = 1'b1;
			bip_pkg::S_DONE: ctl.done = 1'b1;
			default: ;
		endcase
	end
endmodule

/* rtl/bip_dpath.sv */
// Memory, register file and execute logic of the core.
module bip_dpath #(
	parameter int ADDR_BITS = bip_pkg::ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        func,
	input  logic [15:0]       address,
	input  logic [7:0]        write_data,
	input  bip_pkg::ctrl_t    ctl,
	output bip_pkg::stat_t    st,
	output logic [7:0]        read_data,
	output logic [15:0]       program_counter,
	output logic [1:0]        status,
	output logic              done
);
	localparam int DEPTH = 1 << ADDR_BITS;

	logic [7:0]  mem [DEPTH];
	logic [7:0]  rdat_q;
	logic [1:0]  func_q;
	logic [15:0] addr_q;
	logic [7:0]  wdat_q;
	logic [15:0] regs_q [6];
	logic [1:0]  stop_q;
	logic [7:0]  ib_q [4];
	logic [7:0]  dlo_q;
	logic [15:0] daddr_q, dval_q;
	logic [2:0]  ilen_q;
	logic [1:0]  dacc_q;
	logic        dwr_q;
	logic [7:0]  rd_out_q;
	logic        done_q;
	logic [15:0] wbv_q, newpc_q;
	logic [2:0]  wbi_q;
	logic        wbload_q;
	logic [1:0]  newstop_q;

	logic [ADDR_BITS-1:0] base, maddr;
	logic [7:0]  op, b1, b2, b3, wbyte;
	logic [15:0] x1, x2, pc, imm16, imm23, ldb_a;

	function automatic logic [15:0] rr(input logic [7:0] code, input logic [15:0] r [6]);
		logic [2:0] i;
		i = bip_pkg::reg_idx(code);
		rr = (i == 3'd7) ? 16'd0 : r[i];
	endfunction

	function automatic logic [15:0] x_of(input logic [7:0] code);
		x_of = rr(code, regs_q);
	endfunction

	function automatic logic [15:0] rx(input logic [7:0] code, input logic [15:0] npc);
		rx = (code == 8'h00) ? npc : x_of(code);
	endfunction

	assign op = ib_q[0];
	assign b1 = ib_q[1];
	assign b2 = ib_q[2];
	assign b3 = ib_q[3];
	assign pc = regs_q[0];
	assign imm16 = {b2, b1};
	assign imm23 = {b3, b2};
	assign x1 = rr(b1, regs_q);
	assign x2 = rr(b2, regs_q);
	assign ldb_a = rx(b1, pc + 16'd3);

	always_comb begin
		unique case (ctl.asel)
			bip_pkg::AS_PC:   base = pc[ADDR_BITS-1:0];
			bip_pkg::AS_DATA: base = daddr_q[ADDR_BITS-1:0];
			default:          base = addr_q[ADDR_BITS-1:0];
		endcase
		maddr = base + ADDR_BITS'(ctl.offs);
		wbyte = ctl.mem_wr_host ? wdat_q : (ctl.offs[0] ? dval_q[15:8] : dval_q[7:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr_host || ctl.mem_wr_data) mem[maddr] <= wbyte;
		if (ctl.mem_rd) rdat_q <= mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			func_q <= func;
			addr_q <= address;
			wdat_q <= write_data;
		end
		if (ctl.fetch_slot != 3'd0) ib_q[2'(ctl.fetch_slot - 3'd1)] <= rdat_q;
		if (ctl.capture_data && ctl.data_slot == 2'd0) dlo_q <= rdat_q;
	end

	// decode: compute address, store value, write-back target and next pc
	always_ff @(posedge clk) begin
		if (ctl.decode) begin
			dacc_q <= 2'd0;
			dwr_q <= 1'b0;
			daddr_q <= 16'd0;
			dval_q <= x1;
			wbi_q <= 3'd7;
			wbload_q <= 1'b0;
			wbv_q <= 16'd0;
			newstop_q <= bip_pkg::ST_RUN;
			newpc_q <= pc + 16'd3;
			ilen_q <= 3'd3;
			case (op)
				bip_pkg::OP_SET: begin
					wbi_q <= bip_pkg::reg_idx(b1); wbv_q <= {8'd0, b2};
				end
				bip_pkg::OP_SET2: begin
					newpc_q <= pc + 16'd4; ilen_q <= 3'd4;
					wbi_q <= bip_pkg::reg_idx(b1); wbv_q <= imm23;
				end
				bip_pkg::OP_ADD: begin
					newpc_q <= pc + 16'd4; ilen_q <= 3'd4;
					wbi_q <= bip_pkg::reg_idx(b3);
				end
				bip_pkg::OP_ADD2, bip_pkg::OP_SUB2: begin
					newpc_q <= pc + 16'd4; ilen_q <= 3'd4;
					wbi_q <= bip_pkg::reg_idx(b3);
				end
				bip_pkg::OP_LOAD: begin
					dacc_q <= 2'd1; daddr_q <= {8'd0, b1};
					wbi_q <= bip_pkg::reg_idx(b2); wbload_q <= 1'b1;
				end
				bip_pkg::OP_LOAD2: begin
					newpc_q <= pc + 16'd4; ilen_q <= 3'd4;
					dacc_q <= 2'd2; daddr_q <= imm16;
					wbi_q <= bip_pkg::reg_idx(b3); wbload_q <= 1'b1;
				end
				bip_pkg::OP_SAVE: begin
					dacc_q <= 2'd1; dwr_q <= 1'b1; daddr_q <= {8'd0, b2};
				end
				bip_pkg::OP_SAVE2: begin
					newpc_q <= pc + 16'd4; ilen_q <= 3'd4;
					dacc_q <= 2'd2; dwr_q <= 1'b1; daddr_q <= imm23;
				end
				bip_pkg::OP_STW: begin
					dacc_q <= 2'd2; dwr_q <= 1'b1; daddr_q <= x2;
				end
				bip_pkg::OP_STB: begin
					dacc_q <= 2'd1; dwr_q <= 1'b1; daddr_q <= x2;
				end
				bip_pkg::OP_LDB: begin
					dacc_q <= 2'd1; daddr_q <= {8'd0, x1[7:0]};
					wbi_q <= bip_pkg::reg_idx(b2); wbload_q <= 1'b1;
				end
				bip_pkg::OP_LDW: begin
					dacc_q <= 2'd2; daddr_q <= x1;
					wbi_q <= bip_pkg::reg_idx(b2); wbload_q <= 1'b1;
				end
				bip_pkg::OP_CMP: begin
					wbi_q <= 3'd4;
					wbv_q <= (x1 > x2) ? 16'd2 : ((x1 < x2) ? 16'd0 : 16'd1);
				end
				bip_pkg::OP_JLT: if (regs_q[4] == 16'd0) newpc_q <= imm16;
				bip_pkg::OP_JMP: newpc_q <= imm16;
				// operand register sees pc already advanced by two
				bip_pkg::OP_JR: newpc_q <= (b1 == 8'h00) ? pc + 16'd2 : x1;
				bip_pkg::OP_HALT: begin
					newpc_q <= pc + 16'd1; ilen_q <= 3'd1;
					newstop_q <= bip_pkg::ST_HALT;
				end
				default: begin
					newpc_q <= pc; newstop_q <= bip_pkg::ST_ILLEGAL;
				end
			endcase
			// operand pa reads advanced pc: patch values that use it
			if (op == bip_pkg::OP_ADD) begin
				wbv_q <= 16'(rx(b1, pc + 16'd4) & 16'h00FF) + 16'(rx(b2, pc + 16'd4) & 16'h00FF);
			end else if (op == bip_pkg::OP_ADD2) begin
				wbv_q <= rx(b1, pc + 16'd4) + rx(b2, pc + 16'd4);
			end else if (op == bip_pkg::OP_SUB2) begin
				wbv_q <= rx(b1, pc + 16'd4) - rx(b2, pc + 16'd4);
			end else if (op == bip_pkg::OP_CMP) begin
				wbv_q <= (rx(b1, pc + 16'd3) > rx(b2, pc + 16'd3)) ? 16'd2 :
					((rx(b1, pc + 16'd3) < rx(b2, pc + 16'd3)) ? 16'd0 : 16'd1);
			end
			if (op == bip_pkg::OP_SAVE || op == bip_pkg::OP_STB || op == bip_pkg::OP_STW)
				dval_q <= rx(b1, pc + 16'd3);
			if (op == bip_pkg::OP_SAVE2) dval_q <= rx(b1, pc + 16'd4);
			if (op == bip_pkg::OP_STB || op == bip_pkg::OP_STW) daddr_q <= rx(b2, pc + 16'd3);
			if (op == bip_pkg::OP_LDB) daddr_q <= {8'd0, ldb_a[7:0]};
			if (op == bip_pkg::OP_LDW) daddr_q <= rx(b1, pc + 16'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) regs_q[i] <= 16'd0;
			stop_q <= bip_pkg::ST_RUN;
			done_q <= 1'b0;
			rd_out_q <= 8'd0;
		end else begin
			done_q <= ctl.done;
			if (ctl.writeback) begin
				regs_q[0] <= newpc_q;
				stop_q <= newstop_q;
				if (wbi_q != 3'd7) begin
					regs_q[wbi_q] <= wbload_q ?
						((dacc_q == 2'd2) ? {rdat_q, dlo_q} : {8'd0, dlo_q}) : wbv_q;
					if (wbi_q == 3'd0 && newstop_q == bip_pkg::ST_RUN)
						regs_q[0] <= wbload_q ?
							((dacc_q == 2'd2) ? {rdat_q, dlo_q} : {8'd0, dlo_q}) : wbv_q;
				end
			end
			if (ctl.done) rd_out_q <= (func_q == bip_pkg::FUNC_READ) ? rdat_q : 8'd0;
		end
	end

	assign st.func = func_q;
	assign st.stopped = (stop_q != bip_pkg::ST_RUN);
	assign st.ilen = ilen_q;
	assign st.dacc = dacc_q;
	assign st.dwrite = dwr_q;
	assign read_data = rd_out_q;
	assign program_counter = regs_q[0];
	assign status = stop_q;
	assign done = done_q;
endmodule

/* rtl/byte_isa_processor_core.sv */
// Top level of the byte ISA processor core.
// channel | signals                              | handshake
// item    | func, address, write_data            | start && !busy
// result  | read_data, program_counter, status   | done strobe, one cycle
// From acceptance to the strobe, a memory item or an execute on a stopped core passes
// MREAD and DONE; an instruction adds byte-serial fetch of four bytes, a decode state
// and up to two data bytes on the single memory port.
// busy stays high through the strobe cycle; the next word can be taken in the cycle after it.
// Reset clears the register file, stop status and state, not the memory. The receiver cannot stall results.
module byte_isa_processor_core #(
	parameter int ADDR_BITS = bip_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic [15:0] program_counter,
	output logic [1:0]  status
);
	bip_pkg::ctrl_t ctl;
	bip_pkg::stat_t st;
	logic busy_c;
	logic start_c;

	// hold off a new word during the strobe cycle
	assign start_c = start && !done;

	bip_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start_c), .st(st), .ctl(ctl), .busy(busy_c)
	);

	bip_dpath #(.ADDR_BITS(ADDR_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .func(func), .address(address),
		.write_data(write_data), .ctl(ctl), .st(st), .read_data(read_data),
		.program_counter(program_counter), .status(status), .done(done)
	);

	assign busy = busy_c || done;
endmodule

/* rtl/bip_checker.sv */
// Port-level checks for the byte ISA processor core.
module bip_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] program_counter
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("strobe outside busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after accept");
	a_pc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> $stable(program_counter)) else $error("pc moved while idle");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(status) != bip_pkg::ST_RUN && $past(arst_n) |-> status == $past(status))
		else $error("stop cleared");
endmodule

bind byte_isa_processor_core bip_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .program_counter(program_counter)
);

/* bench/byte_isa_processor_core_test.sv */
// Self-checking testbench for the byte ISA processor core.
module byte_isa_processor_core_test;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] addr;
		logic [7:0]  wdata;
		bit          hold;
	} word_t;

	typedef struct {
		logic [7:0]  rdata;
		logic [15:0] pc;
		logic [1:0]  stat;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        done;
	logic [7:0]  read_data;
	logic [15:0] program_counter;
	logic [1:0]  status;

	byte_isa_processor_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .address(address), .write_data(write_data),
		.done(done), .read_data(read_data),
		.program_counter(program_counter), .status(status)
	);

	// core image
	logic [7:0]  mem_img [0:65535];
	bit          known [0:65535];
	logic [15:0] regs [0:5];
	logic [1:0]  stop_code;

	word_t    pending[$];
	outcome_t outcomes[$];
	int       errors;
	int       sent;
	int       got;
	int       gap;
	bit       burst;

	logic [7:0] legal_ops [0:16] = '{bip_pkg::OP_SET, bip_pkg::OP_LOAD, bip_pkg::OP_ADD,
		bip_pkg::OP_SAVE, bip_pkg::OP_CMP, bip_pkg::OP_JLT, bip_pkg::OP_JMP,
		bip_pkg::OP_STB, bip_pkg::OP_SET2, bip_pkg::OP_LOAD2, bip_pkg::OP_ADD2,
		bip_pkg::OP_SAVE2, bip_pkg::OP_SUB2, bip_pkg::OP_LDB, bip_pkg::OP_LDW,
		bip_pkg::OP_STW, bip_pkg::OP_JR};

	function automatic int reg_slot(logic [7:0] code);
		return (code[3:0] == 4'd0 && code[7:4] < 4'd6) ? int'(code[7:4]) : -1;
	endfunction

	function automatic logic [15:0] reg_get(logic [7:0] code);
		int i;
		i = reg_slot(code);
		return i < 0 ? 16'd0 : regs[i];
	endfunction

	function automatic void reg_put(logic [7:0] code, logic [15:0] v);
		int i;
		i = reg_slot(code);
		if (i >= 0)
			regs[i] = v;
	endfunction

	function automatic void mem_put(logic [15:0] a, logic [7:0] v);
		mem_img[a] = v;
		known[a] = 1'b1;
	endfunction

	function automatic logic [15:0] mem_get16(logic [15:0] a);
		return {mem_img[16'(a + 16'd1)], mem_img[a]};
	endfunction

	function automatic void mem_put16(logic [15:0] a, logic [15:0] v);
		mem_put(a, v[7:0]);
		mem_put(16'(a + 16'd1), v[15:8]);
	endfunction

	function automatic int op_len(logic [7:0] op);
		case (op)
			bip_pkg::OP_SET2, bip_pkg::OP_LOAD2, bip_pkg::OP_ADD2, bip_pkg::OP_SAVE2,
			bip_pkg::OP_SUB2, bip_pkg::OP_ADD: return 4;
			bip_pkg::OP_JR: return 2;
			bip_pkg::OP_HALT: return 1;
			default: return 3;
		endcase
	endfunction

	function automatic void run_instr();
		logic [15:0] pc, imm, x, y;
		logic [7:0]  op, b1, b2, b3;
		pc = regs[0];
		op = mem_img[pc];
		b1 = mem_img[16'(pc + 16'd1)];
		b2 = mem_img[16'(pc + 16'd2)];
		b3 = mem_img[16'(pc + 16'd3)];
		imm = {b2, b1};
		case (op)
			bip_pkg::OP_SET: begin
				regs[0] = pc + 16'd3;
				reg_put(b1, {8'd0, b2});
			end
			bip_pkg::OP_SET2: begin
				regs[0] = pc + 16'd4;
				reg_put(b1, {b3, b2});
			end
			bip_pkg::OP_ADD: begin
				regs[0] = pc + 16'd4;
				reg_put(b3, 16'((reg_get(b1) & 16'hFF) + (reg_get(b2) & 16'hFF)));
			end
			bip_pkg::OP_LOAD: begin
				regs[0] = pc + 16'd3;
				reg_put(b2, {8'd0, mem_img[{8'd0, b1}]});
			end
			bip_pkg::OP_LOAD2: begin
				regs[0] = pc + 16'd4;
				reg_put(b3, mem_get16(imm));
			end
			bip_pkg::OP_SAVE: begin
				regs[0] = pc + 16'd3;
				x = reg_get(b1);
				mem_put({8'd0, b2}, x[7:0]);
			end
			bip_pkg::OP_SAVE2: begin
				regs[0] = pc + 16'd4;
				mem_put16({b3, b2}, reg_get(b1));
			end
			bip_pkg::OP_ADD2, bip_pkg::OP_SUB2: begin
				regs[0] = pc + 16'd4;
				x = reg_get(b1);
				y = reg_get(b2);
				reg_put(b3, op == bip_pkg::OP_ADD2 ? 16'(x + y) : 16'(x - y));
			end
			bip_pkg::OP_STW: begin
				regs[0] = pc + 16'd3;
				x = reg_get(b1);
				mem_put16(reg_get(b2), x);
			end
			bip_pkg::OP_LDB: begin
				regs[0] = pc + 16'd3;
				x = reg_get(b1);
				reg_put(b2, {8'd0, mem_img[{8'd0, x[7:0]}]});
			end
			bip_pkg::OP_LDW: begin
				regs[0] = pc + 16'd3;
				reg_put(b2, mem_get16(reg_get(b1)));
			end
			// advance pa first so a pa operand jumps to the next instruction
			bip_pkg::OP_JR: begin
				regs[0] = pc + 16'd2;
				regs[0] = reg_get(b1);
			end
			bip_pkg::OP_CMP: begin
				regs[0] = pc + 16'd3;
				x = reg_get(b1);
				y = reg_get(b2);
				regs[4] = x > y ? 16'd2 : (x < y ? 16'd0 : 16'd1);
			end
			bip_pkg::OP_JLT: begin
				regs[0] = pc + 16'd3;
				if (regs[4] == 16'd0)
					regs[0] = imm;
			end
			bip_pkg::OP_JMP: regs[0] = imm;
			bip_pkg::OP_STB: begin
				regs[0] = pc + 16'd3;
				x = reg_get(b1);
				mem_put(reg_get(b2), x[7:0]);
			end
			bip_pkg::OP_HALT: begin
				regs[0] = pc + 16'd1;
				stop_code = bip_pkg::ST_HALT;
			end
			default: stop_code = bip_pkg::ST_ILLEGAL;
		endcase
	endfunction

	function automatic outcome_t predict_word(word_t w);
		outcome_t r;
		r.rdata = 8'd0;
		if (w.func == bip_pkg::FUNC_WRITE)
			mem_put(w.addr, w.wdata);
		else if (w.func == bip_pkg::FUNC_READ)
			r.rdata = mem_img[w.addr];
		else if (w.func == bip_pkg::FUNC_EXEC && stop_code == bip_pkg::ST_RUN)
			run_instr();
		r.pc = regs[0];
		r.stat = stop_code;
		return r;
	endfunction

	task automatic queue_word(logic [1:0] f, logic [15:0] a, logic [7:0] d, bit h = 0);
		word_t w;
		w.func = f;
		w.addr = a;
		w.wdata = d;
		w.hold = h;
		outcomes.push_back(predict_word(w));
		pending.push_back(w);
	endtask

	task automatic fill(logic [15:0] a);
		if (!known[a])
			queue_word(bip_pkg::FUNC_WRITE, a, 8'($urandom));
	endtask

	// Value an operand sees once pa has moved past the instruction.
	function automatic logic [15:0] operand(logic [7:0] code, logic [15:0] pc_next);
		return reg_slot(code) == 0 ? pc_next : reg_get(code);
	endfunction

	task automatic issue(logic [7:0] op, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
			bit h = 0);
		logic [15:0] pc, pn, a;
		pc = regs[0];
		pn = 16'(pc + op_len(op));
		queue_word(bip_pkg::FUNC_WRITE, pc, op);
		queue_word(bip_pkg::FUNC_WRITE, 16'(pc + 16'd1), b1);
		queue_word(bip_pkg::FUNC_WRITE, 16'(pc + 16'd2), b2);
		queue_word(bip_pkg::FUNC_WRITE, 16'(pc + 16'd3), b3);
		case (op)
			bip_pkg::OP_LOAD: fill({8'd0, b1});
			bip_pkg::OP_LOAD2: begin
				fill({b2, b1});
				fill(16'({b2, b1} + 16'd1));
			end
			bip_pkg::OP_LDB: begin
				a = operand(b1, pn);
				fill({8'd0, a[7:0]});
			end
			bip_pkg::OP_LDW: begin
				a = operand(b1, pn);
				fill(a);
				fill(16'(a + 16'd1));
			end
			default: ;
		endcase
		queue_word(bip_pkg::FUNC_EXEC, 16'($urandom), 8'($urandom), h);
	endtask

	function automatic logic [7:0] pick_reg();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 8'($urandom);
		if (r == 1)
			return 8'h00;
		return 8'($urandom_range(1, 5) << 4);
	endfunction

	task automatic report(string what, int got_v, int exp_v);
		$display("mismatch: %s got %0h expected %0h at %0t", what, got_v, exp_v, $time);
		errors++;
	endtask

	// ---------------- stimulus ----------------
	initial begin
		logic [7:0] op;
		logic [15:0] a;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		for (int i = 0; i < 6; i++)
			regs[i] = 16'd0;
		stop_code = bip_pkg::ST_RUN;

		// address and data extremes, unused func code
		queue_word(bip_pkg::FUNC_WRITE, 16'hFFFF, 8'hFF);
		queue_word(bip_pkg::FUNC_WRITE, 16'h0000, 8'h00);
		queue_word(bip_pkg::FUNC_READ, 16'hFFFF, 8'h00);
		queue_word(bip_pkg::FUNC_READ, 16'h0000, 8'hFF, 1);
		queue_word(bip_pkg::FUNC_NONE, 16'hFFFF, 8'hFF);
		// every opcode but HALT once, then an unknown register and a fetch that wraps
		for (int i = 0; i < 17; i++)
			issue(legal_ops[i], 8'h10, 8'h20, 8'h30);
		issue(bip_pkg::OP_SET, 8'h60, 8'h55, 8'h00);
		issue(bip_pkg::OP_ADD2, 8'h11, 8'h20, 8'h30);
		issue(bip_pkg::OP_JMP, 8'hFE, 8'hFF, 8'h00);
		issue(bip_pkg::OP_SET2, 8'h10, 8'hAA, 8'h55);

		while (pending.size() < 530) begin
			n = $urandom_range(0, 9);
			if (n < 2) begin
				queue_word(bip_pkg::FUNC_WRITE, 16'($urandom), 8'($urandom));
			end else if (n < 4) begin
				a = 16'($urandom);
				fill(a);
				queue_word(bip_pkg::FUNC_READ, a, 8'($urandom), $urandom_range(0, 30) == 0);
			end else if (n == 4 && $urandom_range(0, 3) == 0) begin
				queue_word(bip_pkg::FUNC_NONE, 16'($urandom), 8'($urandom));
			end else begin
				op = legal_ops[$urandom_range(0, 16)];
				issue(op, pick_reg(), $urandom_range(0, 1) ? pick_reg() : 8'($urandom),
					$urandom_range(0, 1) ? pick_reg() : 8'($urandom),
					$urandom_range(0, 30) == 0);
			end
		end

		// stop the core for good, then show it stays stopped
		issue($urandom_range(0, 1) ? bip_pkg::OP_HALT : 8'h11, 8'($urandom), 8'($urandom),
			8'($urandom), 1);
		for (int k = 0; k < 4; k++)
			fill(16'(regs[0] + k));
		queue_word(bip_pkg::FUNC_EXEC, 16'h0000, 8'h00);
		queue_word(bip_pkg::FUNC_READ, 16'hFFFF, 8'h00);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always #5 clk = ~clk;

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		bit acc;
		if (!arst_n) begin
			start <= 1'b0;
			func <= bip_pkg::FUNC_WRITE;
			address <= 16'd0;
			write_data <= 8'd0;
			sent <= 0;
			gap = 0;
			burst = 1'b0;
		end else if (!(start && busy)) begin
			acc = start && !busy;
			if (acc) begin
				sent <= sent + 1;
				if ($urandom_range(0, 15) == 0)
					burst = !burst;
				gap = burst ? 0 : $urandom_range(0, 10);
			end
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending.size() > 0 && (!pending[0].hold || got == sent + acc)) begin
				func <= pending[0].func;
				address <= pending[0].addr;
				write_data <= pending[0].wdata;
				start <= 1'b1;
				void'(pending.pop_front());
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			got <= 0;
		end else if (done) begin
			got <= got + 1;
			if (outcomes.size() == 0) begin
				report("unexpected word, pc", program_counter, 0);
			end else begin
				e = outcomes.pop_front();
				if (read_data !== e.rdata)
					report("read_data", read_data, e.rdata);
				if (program_counter !== e.pc)
					report("program_counter", program_counter, e.pc);
				if (status !== e.stat)
					report("status", status, e.stat);
			end
		end
	end

	// ---------------- end of run ----------------
	initial begin
		@(posedge arst_n);
		do
			@(posedge clk);
		while (pending.size() > 0 || start || outcomes.size() > 0);
		repeat (30) @(posedge clk);
		if (outcomes.size() > 0)
			report("words never returned", outcomes.size(), 0);
		if (errors == 0)
			$display("** byte_isa_processor_core: PASSED **");
		else
			$display("** byte_isa_processor_core: FAILED **");
		$finish;
	end

	initial begin
		#4000000;
		$display("** byte_isa_processor_core: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
rtl/bip_pkg.sv
rtl/bip_ctrl.sv
rtl/bip_dpath.sv
rtl/byte_isa_processor_core.sv
rtl/bip_checker.sv
bench/byte_isa_processor_core_test.sv
